@@ rtl/core/slz_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package slz_pkg;

  // Request codes carried in the req_type field.
  typedef enum logic [2:0] {
    REQ_RX_BYTE    = 3'd0,
    REQ_TX_READY   = 3'd1,
    REQ_LINE_DONE  = 3'd2,
    REQ_CLEAR_EV   = 3'd3,
    REQ_RX_DISABLE = 3'd4,
    REQ_SET_MODE   = 3'd5
  } req_e;

  // Characters with a special meaning on the line.
  localparam logic [7:0] CH_LF   = 8'h0a;
  localparam logic [7:0] CH_CR   = 8'h0d;
  localparam logic [7:0] CH_ZPAD = 8'h2a;
  localparam logic [7:0] CH_ZDLE = 8'h18;

  // Sticky event bits.
  localparam logic [1:0] EV_RX = 2'b01;
  localparam logic [1:0] EV_TX = 2'b10;

  // Both buffer entries 0 and 1 hold ZPAD.
  localparam logic [1:0] PAD_BOTH = 2'b11;

  // Reset value of the inter-character timeout register.
  localparam logic [15:0] TIMEOUT_RESET = 16'd500;

  // One incoming request.
  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] rx_byte;
    logic       new_mode;
  } item_t;

  // Receiver status that does not depend on the buffer depth.
  typedef struct packed {
    logic       armed;
    logic [7:0] err_cnt;
    logic       hdr;
    logic [1:0] pad;
    logic [1:0] ev;
  } flags_t;

  // One result as it leaves the block.
  typedef struct packed {
    logic       wr_valid;
    logic [4:0] wr_index;
    logic [7:0] wr_data;
    logic       term_next;
    logic [1:0] events;
    logic [5:0] line_length;
    logic       header_mode;
    logic       rx_enabled;
    logic [7:0] error_count;
    logic       zmodem_start;
    logic       timer_start;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/core/slz_in_stage.sv @@
`timescale 1ns / 1ps
`default_nettype none

module slz_in_stage (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           valid_i,
  output logic                stall_o,
  input  wire slz_pkg::item_t item_i,
  input  wire logic           take_i,
  output logic                valid_o,
  output slz_pkg::item_t      item_o
);

  logic           valid_q;
  logic           valid_d;
  slz_pkg::item_t item_q;
  logic           load;

  // The held request blocks the input only while the next stage cannot take it.
  assign stall_o = valid_q && !take_i;
  assign load    = valid_i && !stall_o;

  always_comb begin
    valid_d = valid_q;
    if (take_i || !valid_q) begin
      valid_d = valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload is captured on acceptance only.
  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

@@ rtl/core/slz_step.sv @@
`timescale 1ns / 1ps
`default_nettype none

module slz_step #(
  parameter int unsigned BUF_DEPTH = 32,
  parameter int unsigned FillW     = 6
) (
  input  wire slz_pkg::item_t  item_i,
  input  wire logic [FillW-1:0] fill_i,
  input  wire slz_pkg::flags_t flags_i,
  output logic [FillW-1:0]      fill_o,
  output slz_pkg::flags_t       flags_o,
  output slz_pkg::result_t      res_o
);

  localparam int unsigned ExtW = (FillW > 6) ? FillW : 6;
  localparam logic [FillW-1:0] DepthC = FillW'(BUF_DEPTH);
  localparam logic [FillW-1:0] IdxTwo = FillW'(2);
  localparam logic [FillW-1:0] IdxThree = FillW'(3);

  logic [FillW-1:0] fill_inc;
  logic [FillW-1:0] wr_idx;
  logic [ExtW-1:0]  idx_ext;
  logic [ExtW-1:0]  fill_ext;
  logic             not_full;
  logic             wv;
  logic [7:0]       wd;
  logic             tn;
  logic             zs;
  logic             ts;

  // Track whether buffer entries 0 and 1 hold ZPAD after a write.
  function automatic logic [1:0] note_pad(input logic [1:0] pad, input logic [FillW-1:0] idx,
                                          input logic [7:0] data);
    logic [1:0] res;
    res = pad;
    if (idx < IdxTwo) begin
      res[idx[0]] = (data == slz_pkg::CH_ZPAD);
    end
    return res;
  endfunction

  assign fill_inc = fill_i + FillW'(1);
  assign not_full = fill_i < DepthC;

  // Next state and the write request for one item.
  always_comb begin
    fill_o  = fill_i;
    flags_o = flags_i;
    wv      = 1'b0;
    wr_idx  = '0;
    wd      = '0;
    tn      = 1'b0;
    zs      = 1'b0;
    ts      = 1'b0;
    case (slz_pkg::req_e'(item_i.req_type))
      slz_pkg::REQ_RX_BYTE: begin
        if (!flags_i.hdr) begin
          if (item_i.rx_byte == slz_pkg::CH_LF) begin
            // Line feeds are dropped.
          end else if (fill_i == IdxTwo && item_i.rx_byte == slz_pkg::CH_ZDLE &&
                       flags_i.pad == slz_pkg::PAD_BOTH) begin
            // ZPAD ZPAD ZDLE opens a header; no event is raised.
            wv          = 1'b1;
            wr_idx      = IdxTwo;
            wd          = item_i.rx_byte;
            fill_o      = IdxThree;
            flags_o.hdr = 1'b1;
            zs          = 1'b1;
          end else if (flags_i.armed && flags_i.err_cnt == 8'd0 && not_full) begin
            wv     = 1'b1;
            wr_idx = fill_i;
            if (item_i.rx_byte == slz_pkg::CH_CR) begin
              // Carriage return ends the line with a zero terminator.
              wd            = 8'd0;
              flags_o.pad   = note_pad(flags_i.pad, fill_i, 8'd0);
              flags_o.armed = 1'b0;
              flags_o.ev    = flags_i.ev | slz_pkg::EV_RX;
            end else begin
              wd          = item_i.rx_byte;
              flags_o.pad = note_pad(flags_i.pad, fill_i, item_i.rx_byte);
              fill_o      = fill_inc;
            end
          end else begin
            // Rejected byte: count the error and drop the line; a carriage return instead clears the count and re-arms.
            flags_o.err_cnt = flags_i.err_cnt + 8'd1;
            fill_o          = '0;
            if (item_i.rx_byte == slz_pkg::CH_CR) begin
              flags_o.err_cnt = 8'd0;
              flags_o.armed   = 1'b1;
            end
          end
        end else if (flags_i.armed && not_full) begin
          // Header byte, followed by a zero unless it lands in the last entry.
          wv          = 1'b1;
          wr_idx      = fill_i;
          wd          = item_i.rx_byte;
          flags_o.pad = note_pad(flags_i.pad, fill_i, item_i.rx_byte);
          if (fill_inc < DepthC) begin
            tn          = 1'b1;
            flags_o.pad = note_pad(note_pad(flags_i.pad, fill_i, item_i.rx_byte),
                                   fill_inc, 8'd0);
          end
          fill_o     = fill_inc;
          flags_o.ev = flags_i.ev | slz_pkg::EV_RX;
          ts         = 1'b1;
        end
      end
      slz_pkg::REQ_TX_READY: begin
        flags_o.ev = flags_i.ev | slz_pkg::EV_TX;
      end
      slz_pkg::REQ_LINE_DONE: begin
        fill_o        = '0;
        flags_o.armed = 1'b1;
      end
      slz_pkg::REQ_CLEAR_EV: begin
        flags_o.ev = '0;
      end
      slz_pkg::REQ_RX_DISABLE: begin
        flags_o.armed = 1'b0;
      end
      slz_pkg::REQ_SET_MODE: begin
        flags_o.hdr = item_i.new_mode;
      end
      default: begin
        // Unused codes leave the state alone.
      end
    endcase
  end

  // Index and length are reported at the field widths.
  assign idx_ext  = ExtW'(wr_idx);
  assign fill_ext = ExtW'(fill_o);

  always_comb begin
    res_o.wr_valid     = wv;
    res_o.wr_index     = idx_ext[4:0];
    res_o.wr_data      = wd;
    res_o.term_next    = tn;
    res_o.events       = flags_o.ev;
    res_o.line_length  = fill_ext[5:0];
    res_o.header_mode  = flags_o.hdr;
    res_o.rx_enabled   = flags_o.armed;
    res_o.error_count  = flags_o.err_cnt;
    res_o.zmodem_start = zs;
    res_o.timer_start  = ts;
  end

endmodule

`default_nettype wire

@@ rtl/core/serial_line_receiver_zmodem_detect_top.sv @@
// Line receiver with header detection.
// Input channel: in_valid_i / in_stall_o carry one request (req_type_i,
// rx_byte_i, new_mode_i): a received byte or a software event.
// Output channel: out_valid_o / out_stall_i carry the results; every request
// gives exactly one result with the buffer write (wr_valid_o, wr_index_o,
// wr_data_o, term_next_o) and the status after it.
// An accepted request waits in the input register, and its result is then
// captured in the result register: two register stages, with the whole
// update done in the single logic level between them.
// One request per cycle while out_stall_i is low; the input register holds
// one more while a result waits, so the input stalls only if both are full.
// cfg_we_i writes cfg_data_i to the inter-character timeout, which is
// presented on timer_value_o for the timer that timer_start_o reloads.
// Reset empties both stages, arms reception, clears length, error count,
// events and header mode, and sets the timeout to 500 ticks.
`timescale 1ns / 1ps
`default_nettype none

module serial_line_receiver_zmodem_detect_top #(
  parameter int unsigned BUF_DEPTH = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  req_type_i,
  input  wire logic [7:0]  rx_byte_i,
  input  wire logic        new_mode_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             wr_valid_o,
  output logic [4:0]       wr_index_o,
  output logic [7:0]       wr_data_o,
  output logic             term_next_o,
  output logic [1:0]       events_o,
  output logic [5:0]       line_length_o,
  output logic             header_mode_o,
  output logic             rx_enabled_o,
  output logic [7:0]       error_count_o,
  output logic             zmodem_start_o,
  output logic             timer_start_o,
  output logic [15:0]      timer_value_o
);

  localparam int unsigned FillW = $clog2(BUF_DEPTH + 1);

  slz_pkg::item_t   in_item;
  slz_pkg::item_t   st_item;
  logic             st_valid;
  logic             adv;
  logic             proc;
  logic [FillW-1:0] fill_q;
  logic [FillW-1:0] fill_d;
  slz_pkg::flags_t  flags_q;
  slz_pkg::flags_t  flags_d;
  slz_pkg::result_t res_d;
  slz_pkg::result_t res_q;
  logic             out_valid_q;
  logic [15:0]      timeout_q;

  assign in_item.req_type = req_type_i;
  assign in_item.rx_byte  = rx_byte_i;
  assign in_item.new_mode = new_mode_i;

  // The result register moves when it is empty or being taken.
  assign adv  = !out_valid_q || !out_stall_i;
  assign proc = st_valid && adv;

  slz_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .stall_o (in_stall_o),
    .item_i  (in_item),
    .take_i  (adv),
    .valid_o (st_valid),
    .item_o  (st_item)
  );

  slz_step #(
    .BUF_DEPTH (BUF_DEPTH),
    .FillW     (FillW)
  ) u_step (
    .item_i  (st_item),
    .fill_i  (fill_q),
    .flags_i (flags_q),
    .fill_o  (fill_d),
    .flags_o (flags_d),
    .res_o   (res_d)
  );

  // Receiver state advances once per processed request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q          <= '0;
      flags_q.armed   <= 1'b1;
      flags_q.err_cnt <= '0;
      flags_q.hdr     <= 1'b0;
      flags_q.pad     <= '0;
      flags_q.ev      <= '0;
    end else if (proc) begin
      fill_q  <= fill_d;
      flags_q <= flags_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= st_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc) begin
      res_q <= res_d;
    end
  end

  // Inter-character timeout register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= slz_pkg::TIMEOUT_RESET;
    end else if (cfg_we_i) begin
      timeout_q <= cfg_data_i;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign wr_valid_o     = res_q.wr_valid;
  assign wr_index_o     = res_q.wr_index;
  assign wr_data_o      = res_q.wr_data;
  assign term_next_o    = res_q.term_next;
  assign events_o       = res_q.events;
  assign line_length_o  = res_q.line_length;
  assign header_mode_o  = res_q.header_mode;
  assign rx_enabled_o   = res_q.rx_enabled;
  assign error_count_o  = res_q.error_count;
  assign zmodem_start_o = res_q.zmodem_start;
  assign timer_start_o  = res_q.timer_start;
  assign timer_value_o  = timeout_q;

  // A header start writes ZDLE at entry 2 and enters header mode with length 3.
  a_zstart_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zmodem_start_o |-> wr_valid_o && header_mode_o &&
      wr_index_o == 5'd2 && wr_data_o == slz_pkg::CH_ZDLE && line_length_o == 6'd3)
    else $error("header start result malformed");

  // A timer restart only comes with a header byte write and the receive event.
  a_timer_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && timer_start_o |-> wr_valid_o && header_mode_o && events_o[0])
    else $error("timer restart without header write");

  // A trailing zero is only requested together with a write.
  a_term_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && term_next_o |-> wr_valid_o && timer_start_o)
    else $error("trailing zero without write");

  // The input stalls only when a result is waiting on a stalled consumer.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

endmodule

`default_nettype wire
